// ----- rtl/fers_pkg.sv -----
// Package: types, codes and constants of the flash erase range sequencer.
`default_nettype none
package fers_pkg;

  localparam int AW = 24;
  localparam int LW = 25;
  localparam int IDXW = 3;

  localparam logic [1:0] CMD_START    = 2'd0;
  localparam logic [1:0] CMD_FINISHED = 2'd1;
  localparam logic [1:0] CMD_CANCEL   = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_IO_ERROR    = 2'd2;
  localparam logic [1:0] ST_INTERRUPTED = 2'd3;

  localparam logic [1:0] PH_HEAD   = 2'd0;
  localparam logic [1:0] PH_MIDDLE = 2'd1;
  localparam logic [1:0] PH_TAIL   = 2'd2;
  localparam logic [1:0] PH_CHIP   = 2'd3;

  localparam logic [IDXW-1:0] REG_SECTOR_SIZE_LOG2    = 3'd0;
  localparam logic [IDXW-1:0] REG_SMALL_SECTORS_EN    = 3'd1;
  localparam logic [IDXW-1:0] REG_CHIP_SIZE           = 3'd2;
  localparam logic [IDXW-1:0] REG_SECTOR_ERASE_OPCODE = 3'd3;
  localparam logic [IDXW-1:0] REG_SMALL_ERASE_OPCODE  = 3'd4;
  localparam logic [IDXW-1:0] REG_CHIP_ERASE_OPCODE   = 3'd5;

  typedef struct packed {
    logic [1:0]    command;
    logic [AW-1:0] start_address;
    logic [LW-1:0] length;
    logic          step_failed;
  } in_item_t;

  typedef struct packed {
    logic          issue_erase;
    logic [7:0]    opcode;
    logic          with_address;
    logic [AW-1:0] erase_address;
    logic [1:0]    status;
    logic          done_res;
  } out_item_t;

  typedef struct packed {
    logic [4:0]    sector_size_log2;
    logic          small_sectors_enable;
    logic [LW-1:0] chip_size;
    logic [7:0]    sector_erase_opcode;
    logic [7:0]    small_erase_opcode;
    logic [7:0]    chip_erase_opcode;
  } cfg_t;

  typedef struct packed {
    logic          active;
    logic [1:0]    phase;
    logic [AW-1:0] next_address;
    logic [LW-1:0] remaining;
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/fers_cfg.sv -----
// Configuration register file of the flash erase range sequencer.
`default_nettype none
module fers_cfg import fers_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic [IDXW-1:0] cfg_index,
  input  wire logic [LW-1:0]   cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sector_size_log2     <= 5'd16;
      cfg.small_sectors_enable <= 1'b1;
      cfg.chip_size            <= 25'd4194304;
      cfg.sector_erase_opcode  <= 8'd216;
      cfg.small_erase_opcode   <= 8'd32;
      cfg.chip_erase_opcode    <= 8'd199;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SECTOR_SIZE_LOG2:    cfg.sector_size_log2     <= cfg_data[4:0];
        REG_SMALL_SECTORS_EN:    cfg.small_sectors_enable <= cfg_data[0];
        REG_CHIP_SIZE:           cfg.chip_size            <= cfg_data;
        REG_SECTOR_ERASE_OPCODE: cfg.sector_erase_opcode  <= cfg_data[7:0];
        REG_SMALL_ERASE_OPCODE:  cfg.small_erase_opcode   <= cfg_data[7:0];
        REG_CHIP_ERASE_OPCODE:   cfg.chip_erase_opcode    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fers_step.sv -----
// Next-state and result logic for one command of the erase sequencer.
`default_nettype none
module fers_step import fers_pkg::*; #(
  parameter int ADDR_BITS         = 24,
  parameter int SMALL_SECTOR_LOG2 = 12
) (
  input  wire cfg_t     cfg,
  input  wire state_t   state,
  input  wire in_item_t item,
  output logic      res_valid,
  output out_item_t res,
  output state_t    state_next
);

  localparam logic [AW-1:0] ADDR_MASK  = AW'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [LW-1:0] SMALL_SIZE = LW'(64'd1 << SMALL_SECTOR_LOG2);

  localparam out_item_t RES_NONE = '{issue_erase: 1'b0, opcode: 8'd0, with_address: 1'b0,
                                     erase_address: '0, status: ST_OK, done_res: 1'b0};

  logic [4:0]    lg;
  logic [LW-1:0] big_size;
  logic [LW-1:0] big_mask;
  logic [LW-1:0] unit;
  logic          start_mode;
  logic [1:0]    adv_phase;
  logic [AW-1:0] adv_addr;
  logic [LW-1:0] adv_rem;
  out_item_t     adv_res;
  state_t        adv_state;
  state_t        idle_state;

  always_comb begin
    if (cfg.sector_size_log2 < 5'(SMALL_SECTOR_LOG2)) begin
      lg = 5'(SMALL_SECTOR_LOG2);
    end else if (cfg.sector_size_log2 > 5'(ADDR_BITS)) begin
      lg = 5'(ADDR_BITS);
    end else begin
      lg = cfg.sector_size_log2;
    end
  end

  assign big_size = LW'(1) << lg;
  assign big_mask = big_size - LW'(1);
  assign unit     = cfg.small_sectors_enable ? SMALL_SIZE : big_size;

  // start seeds the walk from the request, otherwise continue from state
  assign start_mode = (item.command == CMD_START);
  assign adv_phase  = start_mode ? PH_HEAD : state.phase;
  assign adv_addr   = start_mode ? (item.start_address & ADDR_MASK) : state.next_address;
  assign adv_rem    = start_mode ? item.length : state.remaining;

  always_comb begin
    idle_state              = state;
    idle_state.active       = 1'b0;
    idle_state.phase        = PH_HEAD;
    idle_state.remaining    = '0;
  end

  always_comb begin
    logic [LW-1:0] size;
    logic [7:0]    op;
    logic [1:0]    ph;
    ph   = adv_phase;
    size = big_size;
    op   = cfg.sector_erase_opcode;
    if (cfg.small_sectors_enable) begin
      if (adv_phase == PH_HEAD && (adv_addr & big_mask[AW-1:0]) != '0) begin
        size = SMALL_SIZE;
        op   = cfg.small_erase_opcode;
      end else begin
        if (ph == PH_HEAD) ph = PH_MIDDLE;
        if (ph == PH_MIDDLE && adv_rem >= big_size) begin
          size = big_size;
          op   = cfg.sector_erase_opcode;
        end else begin
          ph   = PH_TAIL;
          size = SMALL_SIZE;
          op   = cfg.small_erase_opcode;
        end
      end
    end
    if (adv_rem == '0) begin
      adv_res                        = RES_NONE;
      adv_res.status                 = ST_OK;
      adv_res.done_res               = 1'b1;
      adv_state                      = idle_state;
      adv_state.next_address         = adv_addr;
    end else begin
      adv_res                        = RES_NONE;
      adv_res.issue_erase            = 1'b1;
      adv_res.opcode                 = op;
      adv_res.with_address           = 1'b1;
      adv_res.erase_address          = adv_addr;
      adv_state.active               = 1'b1;
      adv_state.phase                = ph;
      adv_state.next_address         = (adv_addr + size[AW-1:0]) & ADDR_MASK;
      adv_state.remaining            = (adv_rem > size) ? (adv_rem - size) : '0;
    end
  end

  always_comb begin
    res_valid  = 1'b0;
    res        = RES_NONE;
    state_next = state;
    unique case (item.command)
      CMD_START: begin
        if (!state.active) begin
          res_valid = 1'b1;
          if ((item.length & (unit - LW'(1))) != '0) begin
            res.status   = ST_INVALID;
            res.done_res = 1'b1;
          end else if (item.length == cfg.chip_size) begin
            res.issue_erase         = 1'b1;
            res.opcode              = cfg.chip_erase_opcode;
            state_next.active       = 1'b1;
            state_next.phase        = PH_CHIP;
            state_next.next_address = '0;
            state_next.remaining    = '0;
          end else begin
            res        = adv_res;
            state_next = adv_state;
          end
        end
      end
      CMD_FINISHED: begin
        if (state.active) begin
          res_valid = 1'b1;
          if (item.step_failed) begin
            res.status   = ST_IO_ERROR;
            res.done_res = 1'b1;
            state_next   = idle_state;
          end else begin
            res        = adv_res;
            state_next = adv_state;
          end
        end
      end
      CMD_CANCEL: begin
        if (state.active) begin
          res_valid    = 1'b1;
          res.status   = ST_INTERRUPTED;
          res.done_res = 1'b1;
          state_next   = idle_state;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/flash_erase_range_sequencer_unit.sv -----
// Latency: a result is valid in the cycle after the transfer of the command that causes it.
// Throughput: one command per cycle while the single result register is empty or being taken.
// The command path is one pass of address/length logic from the sequencer state registers.
// Reset (synchronous, rst high): sequencer idle, result register empty,
// configuration registers back to their reset values.
`default_nettype none
module flash_erase_range_sequencer_unit import fers_pkg::*; #(
  parameter int ADDR_BITS         = 24,
  parameter int SMALL_SECTOR_LOG2 = 12
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire in_item_t        in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output out_item_t            out_data,
  input  wire logic            cfg_write,
  input  wire logic [IDXW-1:0] cfg_index,
  input  wire logic [LW-1:0]   cfg_data
);

  cfg_t      cfg;
  state_t    state;
  state_t    state_next;
  logic      res_valid;
  out_item_t res;
  logic      in_xfer;

  fers_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fers_step #(
    .ADDR_BITS         (ADDR_BITS),
    .SMALL_SECTOR_LOG2 (SMALL_SECTOR_LOG2)
  ) u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (in_data),
    .res_valid  (res_valid),
    .res        (res),
    .state_next (state_next)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) state <= state_next;
      if (in_xfer && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) out_data <= res;
  end

endmodule
`default_nettype wire
